/* sv/tts_pkg.sv */
// Package for the tridiagonal solver: payload structs, constants, command/status types.
// No dependencies.
`timescale 1ns / 1ps
package tts_pkg;

    localparam int unsigned MaxRowsDefault = 64;
    localparam int unsigned DataW = 32;
    localparam int unsigned IdxW  = 6;

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusZeroPiv  = 2'd1;
    localparam logic [1:0] StatusTooMany  = 2'd2;

    typedef struct packed {
        logic signed [31:0] sub_diag;
        logic signed [31:0] main_diag;
        logic signed [31:0] super_diag;
        logic signed [31:0] rhs_value;
        logic               last_row;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] solution_value;
        logic [5:0]         row_index;
        logic               last_result;
        logic [1:0]         status;
    } t_out_beat;

    // datapath operand selects
    localparam logic [1:0] NumRow   = 2'd0; // divide sub_diag
    localparam logic [1:0] NumRhs   = 2'd1; // divide stored rhs
    localparam logic [1:0] NumDiff  = 2'd2; // divide subtractor result
    localparam logic [1:0] MulMUp   = 2'd0; // m * upper
    localparam logic [1:0] MulMRhs  = 2'd1; // m * rhs
    localparam logic [1:0] MulUpX   = 2'd2; // upper * x
    localparam logic [1:0] SubDiag  = 2'd0; // b - p
    localparam logic [1:0] SubRhsIn = 2'd1; // d - p
    localparam logic [1:0] SubRhsSt = 2'd2; // stored rhs - p

    typedef struct packed {
        logic       div_start;
        logic [1:0] num_sel;
        logic       mul_start;
        logic [1:0] mul_a_sel;
        logic [1:0] sub_sel;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_zero;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

/* sv/tridiagonal_thomas_solver.sv */
// Top level of the Thomas-algorithm tridiagonal solver, signed Q16.16.
// Depends on tts_pkg, tts_ctrl, tts_datapath.
`timescale 1ns / 1ps
// Rows enter one beat at a time; after a row is accepted the block is ready again once the
// 48-step serial divider has computed the elimination factor and two multiply/subtract
// passes are done; the first row of a system skips both, and a zero pivot ends the divide
// early. On the last row, results leave highest index first, each row below the top
// taking one multiply and one divide; a stalled output holds its result. The block takes
// one system at a time and is not ready while solving.
module tridiagonal_thomas_solver #(
    parameter int unsigned MAX_ROWS = tts_pkg::MaxRowsDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tts_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output tts_pkg::t_out_beat o_data
);
    localparam int unsigned AW = $clog2(MAX_ROWS);
    logic          w_row_ld, w_we_piv, w_we_rhs, w_we_up, w_first, w_rd_ld, w_x_ld;
    logic [AW-1:0] w_waddr, w_raddr;
    tts_pkg::t_cmd  w_cmd;
    tts_pkg::t_stat w_stat;

    tts_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_last(i_data.last_row), .o_ready,
        .o_valid, .i_ready, .o_row_index(o_data.row_index),
        .o_last_result(o_data.last_result), .o_status(o_data.status),
        .o_row_ld(w_row_ld), .o_we_piv(w_we_piv), .o_we_rhs(w_we_rhs),
        .o_we_up(w_we_up), .o_first(w_first), .o_waddr(w_waddr), .o_raddr(w_raddr),
        .o_rd_ld(w_rd_ld), .o_x_ld(w_x_ld), .o_cmd(w_cmd), .i_stat(w_stat));

    tts_datapath #(.MAX_ROWS(MAX_ROWS)) u_dp (
        .i_clk, .i_rst_n, .i_row(i_data), .i_row_ld(w_row_ld), .i_we_piv(w_we_piv),
        .i_we_rhs(w_we_rhs), .i_we_up(w_we_up), .i_first(w_first), .i_waddr(w_waddr),
        .i_raddr(w_raddr), .i_rd_ld(w_rd_ld), .i_x_ld(w_x_ld), .i_cmd(w_cmd),
        .o_stat(w_stat), .o_x(o_data.solution_value));
endmodule

/* sv/tts_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tts_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* sv/tts_div.sv */
// Restoring divider: saturated (num*2^16)/den truncated toward zero, one bit per cycle.
// Depends on tts_pkg.
`timescale 1ns / 1ps
module tts_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_busy,
    output logic               o_zero,
    output logic signed [31:0] o_quot
);
    logic [47:0] r_rem_num;
    logic [31:0] r_den;
    logic [48:0] r_quo;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic        r_busy;
    logic        r_zero;
    logic signed [31:0] r_q;
    logic [33:0] w_try;
    logic [32:0] w_shift;
    logic signed [65:0] w_sq;

    assign w_shift = {r_rem[31:0], r_rem_num[47]};
    assign w_try = {1'b0, w_shift} - {2'b0, r_den};
    assign w_sq = r_neg ? -$signed({17'b0, r_quo}) : $signed({17'b0, r_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_zero <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_neg     <= i_num[31] ^ i_den[31];
            r_rem_num <= {(i_num[31] ? 32'(-i_num) : 32'(i_num)), 16'b0};
            r_den     <= i_den[31] ? 32'(-i_den) : 32'(i_den);
            r_rem     <= '0;
            r_quo     <= '0;
            r_cnt     <= 6'd48;
            r_zero    <= (i_den == 32'sd0);
            r_busy    <= (i_den != 32'sd0);
            if (i_den == 32'sd0) r_q <= '0;
        end else if (r_busy) begin
            if (r_cnt != 6'd0) begin
                r_rem_num <= {r_rem_num[46:0], 1'b0};
                if (!w_try[33]) begin
                    r_rem <= w_try[32:0];
                    r_quo <= {r_quo[47:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[47:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
            end else begin
                r_q    <= tts_pkg::sat32(w_sq);
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_zero = r_zero;
    assign o_quot = r_q;
endmodule

/* sv/tts_datapath.sv */
// Datapath: row stores, divider, multiplier and subtractor for the solver.
// Depends on tts_pkg, tts_ram, tts_div.
`timescale 1ns / 1ps
module tts_datapath #(
    parameter int unsigned MAX_ROWS = tts_pkg::MaxRowsDefault,
    localparam int unsigned AW = $clog2(MAX_ROWS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tts_pkg::t_in_beat     i_row,
    input  logic                  i_row_ld,
    input  logic                  i_we_piv,
    input  logic                  i_we_rhs,
    input  logic                  i_we_up,
    input  logic                  i_first,
    input  logic [AW-1:0]         i_waddr,
    input  logic [AW-1:0]         i_raddr,
    input  logic                  i_rd_ld,
    input  logic                  i_x_ld,
    input  tts_pkg::t_cmd         i_cmd,
    output tts_pkg::t_stat        o_stat,
    output logic signed [31:0]    o_x
);
    tts_pkg::t_in_beat r_row;
    logic signed [31:0] w_piv, w_rhs, w_up;
    logic signed [31:0] r_piv, r_rhs, r_up;
    logic signed [31:0] r_m, r_x, r_p, r_s;
    logic signed [63:0] r_prod;
    logic signed [31:0] w_num, w_ma, w_mb, w_sa, w_q;
    logic signed [31:0] n_piv_w, n_rhs_w;
    logic               r_pdone;
    logic signed [63:0] w_pr;

    tts_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_piv (.i_clk, .i_we(i_we_piv),
        .i_waddr(i_waddr), .i_wdata(n_piv_w), .i_raddr(i_raddr), .o_rdata(w_piv));
    tts_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_rhs (.i_clk, .i_we(i_we_rhs),
        .i_waddr(i_waddr), .i_wdata(n_rhs_w), .i_raddr(i_raddr), .o_rdata(w_rhs));
    tts_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_up (.i_clk, .i_we(i_we_up),
        .i_waddr(i_waddr), .i_wdata(r_row.super_diag), .i_raddr(i_raddr),
        .o_rdata(w_up));

    assign n_piv_w = i_first ? r_row.main_diag : r_s;
    assign n_rhs_w = i_first ? r_row.rhs_value : r_s;

    always_comb begin
        case (i_cmd.num_sel)
            tts_pkg::NumRow: w_num = r_row.sub_diag;
            tts_pkg::NumRhs: w_num = r_rhs;
            default:         w_num = r_s;
        endcase
        case (i_cmd.mul_a_sel)
            tts_pkg::MulMUp:  begin w_ma = r_m;  w_mb = r_up;  end
            tts_pkg::MulMRhs: begin w_ma = r_m;  w_mb = r_rhs; end
            default:          begin w_ma = r_up; w_mb = r_x;   end
        endcase
        case (i_cmd.sub_sel)
            tts_pkg::SubDiag:  w_sa = r_row.main_diag;
            tts_pkg::SubRhsIn: w_sa = r_row.rhs_value;
            default:           w_sa = r_rhs;
        endcase
    end

    tts_div u_div (.i_clk, .i_rst_n, .i_start(i_cmd.div_start), .i_num(w_num),
        .i_den(r_piv), .o_busy(o_stat.div_busy), .o_zero(o_stat.div_zero), .o_quot(w_q));

    assign w_pr = r_prod + 64'sd32768;

    always_ff @(posedge i_clk) begin
        if (i_row_ld) r_row <= i_row;
        if (i_rd_ld) begin
            r_piv <= w_piv;
            r_rhs <= w_rhs;
            r_up  <= w_up;
        end
        if (i_cmd.mul_start) r_prod <= w_ma * w_mb;
        r_pdone <= i_cmd.mul_start;
        if (r_pdone) r_p <= tts_pkg::sat32(66'(w_pr >>> 16));
        r_s <= tts_pkg::sat32(66'(w_sa) - 66'(r_p));
        if (i_x_ld) r_x <= w_q;
        r_m <= w_q;
    end

    assign o_x = r_x;
endmodule

/* sv/tts_ctrl.sv */
// Controller state machine: row intake, forward elimination and back substitution sequencing.
// Depends on tts_pkg.
`timescale 1ns / 1ps
module tts_ctrl #(
    parameter int unsigned MAX_ROWS = tts_pkg::MaxRowsDefault,
    localparam int unsigned AW = $clog2(MAX_ROWS),
    localparam int unsigned CW = $clog2(MAX_ROWS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_last,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [5:0]           o_row_index,
    output logic                 o_last_result,
    output logic [1:0]           o_status,
    output logic                 o_row_ld,
    output logic                 o_we_piv,
    output logic                 o_we_rhs,
    output logic                 o_we_up,
    output logic                 o_first,
    output logic [AW-1:0]        o_waddr,
    output logic [AW-1:0]        o_raddr,
    output logic                 o_rd_ld,
    output logic                 o_x_ld,
    output tts_pkg::t_cmd        o_cmd,
    input  tts_pkg::t_stat       i_stat
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2, S_FDIV = 4'd3,
        S_FWAIT = 4'd4, S_FMUL1 = 4'd5, S_FMUL2 = 4'd6, S_FW1 = 4'd7, S_FW2 = 4'd8,
        S_FSUB2 = 4'd9, S_BRD = 4'd10, S_BRDW = 4'd11, S_BMUL = 4'd12, S_BSUB = 4'd13,
        S_BDIV = 4'd14, S_BOUT = 4'd15;

    logic [3:0]    r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_br, n_br;
    logic [1:0]    r_err, n_err;
    logic          r_last, n_last;
    logic          r_top, n_top;
    logic [2:0]    r_wt, n_wt;
    logic          r_ov, n_ov;
    logic          r_dg, n_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_br <= '0; r_err <= '0;
            r_last <= 1'b0; r_top <= 1'b0; r_wt <= '0; r_ov <= 1'b0; r_dg <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_br <= n_br; r_err <= n_err;
            r_last <= n_last; r_top <= n_top; r_wt <= n_wt; r_ov <= n_ov; r_dg <= n_dg;
        end
    end

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_BOUT);
    assign o_row_index = 6'(r_br);
    assign o_last_result = (r_br == '0);
    assign o_status = r_err;
    assign o_waddr = r_cnt[AW-1:0];

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_br = r_br; n_err = r_err; n_last = r_last;
        n_top = r_top; n_wt = r_wt; n_ov = r_ov; n_dg = r_dg;
        o_row_ld = 1'b0; o_we_piv = 1'b0; o_we_rhs = 1'b0; o_we_up = 1'b0;
        o_first = 1'b0; o_raddr = r_br; o_rd_ld = 1'b0; o_x_ld = 1'b0;
        o_cmd = '0;
        unique case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    o_row_ld = 1'b1;
                    n_last = i_last;
                    n_ov = (r_cnt >= CW'(MAX_ROWS));
                    n_st = S_RD;
                end
            end
            S_RD: begin
                o_raddr = r_cnt[AW-1:0] - AW'(1);
                if (r_ov) begin
                    n_err = tts_pkg::StatusTooMany;
                    n_st = S_FW2;
                end else if (r_cnt == '0) begin
                    o_first = 1'b1;
                    o_we_piv = 1'b1; o_we_rhs = 1'b1; o_we_up = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                    n_st = S_FW2;
                end else n_st = S_RDW;
            end
            S_RDW: begin
                o_rd_ld = 1'b1;
                n_st = S_FDIV;
            end
            S_FDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.num_sel = tts_pkg::NumRow;
                n_st = S_FWAIT;
                n_dg = 1'b0;
            end
            S_FWAIT: begin
                if (!i_stat.div_busy && n_dg == r_dg) begin
                    if (r_dg) begin
                        if (i_stat.div_zero && r_err == tts_pkg::StatusOk)
                            n_err = tts_pkg::StatusZeroPiv;
                        n_st = S_FMUL1;
                        n_wt = '0;
                    end else n_dg = 1'b1;
                end
            end
            S_FMUL1: begin
                // r_m holds m; b - m*c(i-1)
                if (r_wt == 3'd0) begin
                    o_cmd.mul_start = 1'b1; o_cmd.mul_a_sel = tts_pkg::MulMUp;
                end
                o_cmd.sub_sel = tts_pkg::SubDiag;
                n_wt = r_wt + 3'd1;
                if (r_wt == 3'd3) begin
                    o_we_piv = 1'b1;
                    n_wt = '0;
                    n_st = S_FMUL2;
                end
            end
            S_FMUL2: begin
                if (r_wt == 3'd0) begin
                    o_cmd.mul_start = 1'b1; o_cmd.mul_a_sel = tts_pkg::MulMRhs;
                end
                o_cmd.sub_sel = tts_pkg::SubRhsIn;
                n_wt = r_wt + 3'd1;
                if (r_wt == 3'd3) begin
                    o_we_rhs = 1'b1; o_we_up = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                    n_st = S_FW2;
                end
            end
            S_FW1: n_st = S_FW2;
            S_FW2: begin
                if (r_last) begin
                    n_br = AW'(r_cnt - CW'(1));
                    n_top = 1'b1;
                    n_st = S_BRD;
                end else n_st = S_IDLE;
            end
            S_FSUB2: n_st = S_IDLE;
            S_BRD: n_st = S_BRDW;
            S_BRDW: begin
                o_rd_ld = 1'b1;
                n_wt = '0;
                n_st = r_top ? S_BDIV : S_BMUL;
            end
            S_BMUL: begin
                if (r_wt == 3'd0) begin
                    o_cmd.mul_start = 1'b1; o_cmd.mul_a_sel = tts_pkg::MulUpX;
                end
                o_cmd.sub_sel = tts_pkg::SubRhsSt;
                n_wt = r_wt + 3'd1;
                if (r_wt == 3'd3) n_st = S_BSUB;
            end
            S_BSUB: begin
                o_cmd.div_start = 1'b1;
                o_cmd.num_sel = tts_pkg::NumDiff;
                n_dg = 1'b0;
                n_st = S_BDIV;
            end
            S_BDIV: begin
                if (r_top && r_wt == 3'd0) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.num_sel = tts_pkg::NumRhs;
                    n_wt = 3'd1;
                    n_dg = 1'b0;
                end else if (!i_stat.div_busy) begin
                    if (r_dg) begin
                        if (i_stat.div_zero && r_err == tts_pkg::StatusOk)
                            n_err = tts_pkg::StatusZeroPiv;
                        o_x_ld = 1'b1;
                        n_st = S_BOUT;
                    end else n_dg = 1'b1;
                end
            end
            S_BOUT: begin
                if (i_ready) begin
                    n_top = 1'b0;
                    if (r_br == '0) begin
                        n_cnt = '0; n_err = tts_pkg::StatusOk;
                        n_st = S_IDLE;
                    end else begin
                        n_br = r_br - AW'(1);
                        n_st = S_BRD;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end
endmodule

/* sv/tts_checker.sv */
// Port-level checker for the tridiagonal solver, bound to the top level.
// Depends on tts_pkg and tridiagonal_thomas_solver.
`timescale 1ns / 1ps
module tts_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input tts_pkg::t_out_beat o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("output dropped");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("ready while presenting result");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status != 2'd3) else $error("bad status");
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_data.last_result |=> !o_valid) else $error("extra result");
endmodule

bind tridiagonal_thomas_solver tts_port_checker u_chk (.*);
